// ----- rtl/imu_cal_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU static calibration package
// Shared types and constants for the static calibration block.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_REJ  = 2'd2;
  localparam logic [1:0] ST_INV  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_GYRO_RATE = 3'd0;
  localparam logic [2:0] REG_NORM_LO   = 3'd1;
  localparam logic [2:0] REG_NORM_HI   = 3'd2;
  localparam logic [2:0] REG_ACC_VAR   = 3'd3;
  localparam logic [2:0] REG_GYRO_VAR  = 3'd4;
  localparam logic [2:0] REG_GYRO_BIAS = 3'd5;

  // Register reset values.
  localparam logic [14:0] RST_GYRO_RATE = 15'd1280;
  localparam logic [31:0] RST_NORM_LO   = 32'd217432719;
  localparam logic [31:0] RST_NORM_HI   = 32'd324806902;
  localparam logic [31:0] RST_ACC_VAR   = 32'd60398;
  localparam logic [31:0] RST_GYRO_VAR  = 32'd4096;
  localparam logic [14:0] RST_GYRO_BIAS = 15'd640;

  localparam int NCH = 6;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_ACC   = 13'b0000000000100,
    S_JUDGE = 13'b0000000001000,
    S_RD    = 13'b0000000010000,
    S_DLT   = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_UPD   = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_WB    = 13'b0001000000000,
    S_CHK   = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

endpackage

// ----- rtl/imu_cal_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imu_cal_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/imu_cal_div.sv -----
// ----------------------------------------------------------------------------
// Unsigned restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module imu_cal_div #(
  parameter int NW  = 33,
  parameter int DVW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [DVW-1:0]       den,
  output logic                 done,
  output logic [NW-1:0]        quo
);

  localparam int IW = $clog2(NW + 1);

  logic [NW-1:0]  num_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] den_r;
  logic [IW-1:0]  it_r;
  logic           busy_r;
  logic           done_r;
  logic [DVW:0]   rem_s;
  logic           ge;

  assign rem_s = {rem_r, num_r[NW-1]};
  assign ge    = rem_s >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= IW'(NW);
      end else if (busy_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == IW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= ge ? DVW'(rem_s - {1'b0, den_r}) : rem_s[DVW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ----- rtl/imu_static_calibration_welford.sv -----
// ----------------------------------------------------------------------------
// IMU static calibration, Welford running mean and variance
// Gates 6-axis samples, tracks six running means and M2 sums, judges a session.
// ----------------------------------------------------------------------------
// Each input beat carries one 6-axis sample (accel in 2^-14 g, gyro in 2^-7
// dps) or, with in_tuser set, a restart of the calibration session. Every input
// beat produces exactly one result beat with a status, the accepted sample count
// and the six running means rounded to input LSBs. A restart and an ignored
// sample (session already rejected or full) go from idle straight to the emit
// state; a sample refused by the gyro-rate or accel-norm gate goes there once
// the norm check is done. An accepted sample loads the result only after the
// norm check and all six channel updates are through, plus any wait for the
// output register: the norm check uses one shared multiplier over three
// squares, and then each of the six channels does a read-modify-write of its
// mean and M2 word in the state RAM, where the mean step is a division by the
// sample count on a bit-serial divider that yields one quotient bit per cycle.
// The state RAM needs no clearing pass; a six-bit valid mask makes unwritten
// entries read as zero, and a restart simply clears the mask. The block takes
// the next input beat while a finished result still waits on the output
// register.
// ----------------------------------------------------------------------------
module imu_static_calibration_welford #(
  parameter int TARGET_SAMPLES     = 256,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic         in_tuser,   // action
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // samples_taken, accel_mean_x/y/z, gyro_mean_x/y/z, zero pad
  output logic [1:0]   out_tuser,  // status
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int F   = MEAN_FRACTION_BITS;
  localparam int CW  = $clog2(TARGET_SAMPLES + 1);  // sample counter width
  localparam int MW  = 16 + F;                      // stored mean width
  localparam int DW  = MW + 1;                      // delta width
  localparam int PW  = DW - (F - 8);                // M2 factor width
  localparam int RW  = MW + 64;                     // RAM word: {m2, mean}
  localparam int BW  = 32 + CW;                     // variance bound width
  localparam logic [CW-1:0] TGT = CW'(TARGET_SAMPLES);

  // Configuration registers.
  logic [14:0] rate_lim_r;
  logic [31:0] norm_lo_r, norm_hi_r, acc_var_r, gyro_var_r;
  logic [14:0] bias_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_lim_r <= imu_cal_pkg::RST_GYRO_RATE;
      norm_lo_r  <= imu_cal_pkg::RST_NORM_LO;
      norm_hi_r  <= imu_cal_pkg::RST_NORM_HI;
      acc_var_r  <= imu_cal_pkg::RST_ACC_VAR;
      gyro_var_r <= imu_cal_pkg::RST_GYRO_VAR;
      bias_lim_r <= imu_cal_pkg::RST_GYRO_BIAS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        imu_cal_pkg::REG_GYRO_RATE: rate_lim_r <= cfg_wdata[14:0];
        imu_cal_pkg::REG_NORM_LO:   norm_lo_r  <= cfg_wdata;
        imu_cal_pkg::REG_NORM_HI:   norm_hi_r  <= cfg_wdata;
        imu_cal_pkg::REG_ACC_VAR:   acc_var_r  <= cfg_wdata;
        imu_cal_pkg::REG_GYRO_VAR:  gyro_var_r <= cfg_wdata;
        imu_cal_pkg::REG_GYRO_BIAS: bias_lim_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Rounds a stored mean to input LSBs, saturated to 16 bits.
  function automatic logic [15:0] mean_out(input logic signed [MW-1:0] m);
    logic signed [MW:0] t;
    logic [16:0]        r;
    t = {m[MW-1], m} + ((MW+1)'(1) << (F - 1));
    r = t[MW:F];
    if (r[16] != r[15]) begin
      mean_out = r[16] ? 16'h8000 : 16'h7fff;
    end else begin
      mean_out = r[15:0];
    end
  endfunction

  imu_cal_pkg::state_t st_r;

  // The sample sits in a rotating line so the channel in work is always at
  // position 0. Three rotations during the norm check bring the gyro axes to
  // the front, so the channels are then walked in the order 3,4,5,0,1,2.
  logic signed [15:0] smp_r [imu_cal_pkg::NCH];
  logic [1:0]         k_r;
  logic [2:0]         ch_r;
  logic [31:0]        sq_r, norm_r;
  logic [CW-1:0]      cnt_r;
  logic               rej_r;
  logic               fail_r;
  logic [5:0]         vld_r;
  logic [15:0]        mq_r [imu_cal_pkg::NCH];
  logic [1:0]         status_r;

  logic signed [MW-1:0] mean_r, nm_r;
  logic signed [63:0]   m2_r, m2n_r;
  logic signed [DW-1:0] x_r, q_r;
  logic                 dneg_r;
  logic signed [PW-1:0] d1_r, d2_r;
  logic signed [2*PW-1:0] prod_r;
  logic [BW-1:0]        bnd_r;

  logic         out_v_r;
  logic [111:0] out_d_r;
  logic [1:0]   out_u_r;

  // State RAM and divider.
  logic [RW-1:0] ram_rdata;
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_num, div_quo;

  imu_cal_ram #(.W(RW), .D(imu_cal_pkg::NCH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_r),
    .wdata (ram_wdata),
    .raddr (ch_r),
    .rdata (ram_rdata)
  );

  imu_cal_div #(.NW(DW), .DVW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Combinational helpers.
  logic                 in_fire;
  logic signed [MW-1:0] rd_mean;
  logic signed [63:0]   rd_m2;
  logic signed [DW-1:0] x_c, delta_c, d2_c;
  logic signed [MW-1:0] nm_c;
  logic signed [64:0]   sum_c;
  logic signed [63:0]   m2_sat;
  logic                 gyro_bad, norm_bad, var_bad, bias_bad;
  logic [16:0]          g0, g1, g2;
  logic [MW:0]          abs_m;
  logic [63:0]          q_ext, b_ext;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (st_r == imu_cal_pkg::S_IDLE);

  assign rd_mean = vld_r[ch_r] ? ram_rdata[MW-1:0] : '0;
  assign rd_m2   = vld_r[ch_r] ? ram_rdata[RW-1:MW] : '0;
  assign x_c     = DW'(smp_r[0]) <<< F;
  assign delta_c = x_c - DW'(rd_mean);
  assign div_num = delta_c[DW-1] ? DW'(-delta_c) : delta_c;
  assign div_start = (st_r == imu_cal_pkg::S_DLT);

  assign nm_c = MW'(DW'(mean_r) + q_r);
  assign d2_c = x_r - DW'(nm_c);

  assign sum_c  = {m2_r[63], m2_r} + 65'(prod_r);
  assign m2_sat = (sum_c[64] != sum_c[63]) ?
                  (sum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_c[63:0];
  assign ram_we    = (st_r == imu_cal_pkg::S_WB);
  assign ram_wdata = {m2_sat, nm_r};

  // Gyro magnitude gate: positions 0..2 hold the gyro axes in the judge state.
  assign g0 = smp_r[0][15] ? 17'(-18'(smp_r[0])) : 17'(smp_r[0]);
  assign g1 = smp_r[1][15] ? 17'(-18'(smp_r[1])) : 17'(smp_r[1]);
  assign g2 = smp_r[2][15] ? 17'(-18'(smp_r[2])) : 17'(smp_r[2]);
  assign gyro_bad = (g0 > 17'(rate_lim_r)) || (g1 > 17'(rate_lim_r)) ||
                    (g2 > 17'(rate_lim_r));
  assign norm_bad = (norm_r < norm_lo_r) || (norm_r > norm_hi_r);

  // Variance test: M2 > limit*(n-1)*2^16, with M2 <= 0 treated as passing.
  assign q_ext   = 64'(m2n_r[63:16]);
  assign b_ext   = 64'(bnd_r);
  assign var_bad = (cnt_r >= CW'(2)) && !m2n_r[63] && (m2n_r != '0) &&
                   ((q_ext > b_ext) || ((q_ext == b_ext) && (m2n_r[15:0] != '0)));
  assign abs_m    = nm_r[MW-1] ? (MW+1)'(-(MW+1)'(nm_r)) : (MW+1)'(nm_r);
  assign bias_bad = (ch_r >= 3'd3) && (abs_m > ((MW+1)'(bias_lim_r) << F));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= imu_cal_pkg::S_IDLE;
      cnt_r   <= '0;
      rej_r   <= 1'b0;
      vld_r   <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < imu_cal_pkg::NCH; i++) begin
        mq_r[i] <= '0;
      end
    end else begin
      // The emit state reloads the output register itself when it is taken.
      if (out_v_r && out_tready && (st_r != imu_cal_pkg::S_EMIT)) begin
        out_v_r <= 1'b0;
      end
      unique case (st_r)
        imu_cal_pkg::S_IDLE: begin
          if (in_fire) begin
            for (int i = 0; i < imu_cal_pkg::NCH; i++) begin
              smp_r[i] <= in_tdata[16*i +: 16];
            end
            if (in_tuser) begin
              cnt_r    <= '0;
              rej_r    <= 1'b0;
              vld_r    <= '0;
              for (int i = 0; i < imu_cal_pkg::NCH; i++) begin
                mq_r[i] <= '0;
              end
              status_r <= imu_cal_pkg::ST_OK;
              st_r     <= imu_cal_pkg::S_EMIT;
            end else if (rej_r || (cnt_r >= TGT)) begin
              status_r <= imu_cal_pkg::ST_INV;
              st_r     <= imu_cal_pkg::S_EMIT;
            end else begin
              k_r    <= '0;
              norm_r <= '0;
              st_r   <= imu_cal_pkg::S_SQ;
            end
          end
        end
        imu_cal_pkg::S_SQ: begin
          sq_r <= 32'(smp_r[0]) * 32'(smp_r[0]);
          st_r <= imu_cal_pkg::S_ACC;
        end
        imu_cal_pkg::S_ACC: begin
          norm_r <= norm_r + sq_r;
          for (int i = 0; i < imu_cal_pkg::NCH; i++) begin
            smp_r[i] <= smp_r[(i + 1) % imu_cal_pkg::NCH];
          end
          k_r  <= k_r + 1'b1;
          st_r <= (k_r == 2'd2) ? imu_cal_pkg::S_JUDGE : imu_cal_pkg::S_SQ;
        end
        imu_cal_pkg::S_JUDGE: begin
          if (gyro_bad || norm_bad) begin
            rej_r    <= 1'b1;
            status_r <= imu_cal_pkg::ST_REJ;
            st_r     <= imu_cal_pkg::S_EMIT;
          end else begin
            cnt_r  <= cnt_r + 1'b1;
            ch_r   <= 3'd3;
            fail_r <= 1'b0;
            st_r   <= imu_cal_pkg::S_RD;
          end
        end
        imu_cal_pkg::S_RD: begin
          st_r <= imu_cal_pkg::S_DLT;
        end
        imu_cal_pkg::S_DLT: begin
          mean_r <= rd_mean;
          m2_r   <= rd_m2;
          x_r    <= x_c;
          dneg_r <= delta_c[DW-1];
          st_r   <= imu_cal_pkg::S_DIV;
        end
        imu_cal_pkg::S_DIV: begin
          if (div_done) begin
            q_r  <= dneg_r ? -div_quo : div_quo;
            st_r <= imu_cal_pkg::S_UPD;
          end
        end
        imu_cal_pkg::S_UPD: begin
          // Both M2 factors are floored to 8 fraction bits.
          nm_r <= nm_c;
          d1_r <= PW'((x_r - DW'(mean_r)) >>> (F - 8));
          d2_r <= PW'(d2_c >>> (F - 8));
          st_r <= imu_cal_pkg::S_MUL;
        end
        imu_cal_pkg::S_MUL: begin
          prod_r <= d1_r * d2_r;
          bnd_r  <= (ch_r < 3'd3 ? acc_var_r : gyro_var_r) * (cnt_r - 1'b1);
          st_r   <= imu_cal_pkg::S_WB;
        end
        imu_cal_pkg::S_WB: begin
          m2n_r       <= m2_sat;
          vld_r[ch_r] <= 1'b1;
          mq_r[ch_r]  <= mean_out(nm_r);
          st_r        <= imu_cal_pkg::S_CHK;
        end
        imu_cal_pkg::S_CHK: begin
          if (cnt_r == TGT && (var_bad || bias_bad)) begin
            fail_r <= 1'b1;
          end
          for (int i = 0; i < imu_cal_pkg::NCH; i++) begin
            smp_r[i] <= smp_r[(i + 1) % imu_cal_pkg::NCH];
          end
          if (ch_r == 3'd2) begin
            st_r <= imu_cal_pkg::S_FIN;
          end else begin
            ch_r <= (ch_r == 3'd5) ? 3'd0 : ch_r + 1'b1;
            st_r <= imu_cal_pkg::S_RD;
          end
        end
        imu_cal_pkg::S_FIN: begin
          if (cnt_r == TGT) begin
            if (fail_r) begin
              rej_r    <= 1'b1;
              status_r <= imu_cal_pkg::ST_REJ;
            end else begin
              status_r <= imu_cal_pkg::ST_PASS;
            end
          end else begin
            status_r <= imu_cal_pkg::ST_OK;
          end
          st_r <= imu_cal_pkg::S_EMIT;
        end
        imu_cal_pkg::S_EMIT: begin
          if (!out_v_r || out_tready) begin
            out_v_r <= 1'b1;
            out_u_r <= status_r;
            out_d_r <= {7'd0, mq_r[5], mq_r[4], mq_r[3], mq_r[2], mq_r[1], mq_r[0],
                        9'(cnt_r)};
            st_r    <= imu_cal_pkg::S_IDLE;
          end
        end
        default: st_r <= imu_cal_pkg::S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

`ifndef ASSERT_OFF
  // A passed session always reports the full target count.
  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == imu_cal_pkg::ST_PASS) |->
      (out_tdata[8:0] == 9'(TARGET_SAMPLES)))
    else $error("passed result without full sample count");

  // The divider never runs with a zero divisor.
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == imu_cal_pkg::S_DIV) |-> (cnt_r != '0))
    else $error("division by zero sample count");

  // The channel pointer stays on a RAM entry.
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == imu_cal_pkg::S_WB) |-> (ch_r <= 3'd5))
    else $error("channel index out of range");
`endif

endmodule

// ----- tb/imu_static_calibration_welford_tb.sv -----
// ----------------------------------------------------------------------------
// IMU static calibration testbench
// Drives samples and restarts into the calibration block, predicts every
// result beat with a cycle-free Welford model, and checks beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_static_calibration_welford_tb;

  localparam int TARGET = 256;
  localparam int FRAC   = 16;

  // One input beat: restart flag plus accel x,y,z and gyro x,y,z.
  typedef struct {
    bit      restart;
    shortint ch[6];
  } imu_beat_t;

  // One expected result beat.
  typedef struct {
    logic [1:0]  status;
    logic [8:0]  count;
    logic [15:0] mean[6];
  } cal_result_t;

  // Scoreboard: owns a copy of the session state and the registers, predicts
  // the result of each accepted beat and checks result beats in order.
  class calib_scoreboard;
    int unsigned rate_lim, norm_lo, norm_hi, acc_var_lim, gyro_var_lim, bias_lim;
    int unsigned n_samples;
    longint      mean_acc[6];
    longint      m2_acc[6];
    bit          rejected;
    cal_result_t expected_results[$];
    int          errors;

    function new();
      rate_lim     = imu_cal_pkg::RST_GYRO_RATE;
      norm_lo      = imu_cal_pkg::RST_NORM_LO;
      norm_hi      = imu_cal_pkg::RST_NORM_HI;
      acc_var_lim  = imu_cal_pkg::RST_ACC_VAR;
      gyro_var_lim = imu_cal_pkg::RST_GYRO_VAR;
      bias_lim     = imu_cal_pkg::RST_GYRO_BIAS;
      clear_session();
      errors = 0;
    endfunction

    function void clear_session();
      n_samples = 0;
      rejected  = 0;
      foreach (mean_acc[i]) begin
        mean_acc[i] = 0;
        m2_acc[i]   = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        imu_cal_pkg::REG_GYRO_RATE: rate_lim     = val[14:0];
        imu_cal_pkg::REG_NORM_LO:   norm_lo      = val;
        imu_cal_pkg::REG_NORM_HI:   norm_hi      = val;
        imu_cal_pkg::REG_ACC_VAR:   acc_var_lim  = val;
        imu_cal_pkg::REG_GYRO_VAR:  gyro_var_lim = val;
        imu_cal_pkg::REG_GYRO_BIAS: bias_lim     = val[14:0];
        default: ;
      endcase
    endfunction

    // Round a fixed-point mean to input LSBs, saturating to 16 bits.
    function logic [15:0] rounded_mean(longint m);
      longint r;
      r = (m + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function longint sat_sum(longint a, longint b);
      longint max_v, min_v;
      max_v = 64'h7FFF_FFFF_FFFF_FFFF;
      min_v = 64'h8000_0000_0000_0000;
      if (b > 0 && a > max_v - b) return max_v;
      if (b < 0 && a < min_v - b) return min_v;
      return a + b;
    endfunction

    // M2 holds LSB^2 with 16 fraction bits; compare against limit*(n-1) exactly.
    function bit variance_over(longint m2, int unsigned lim, int unsigned n);
      longint unsigned m, q, bound;
      if (n < 2 || m2 <= 0) return 0;
      m     = m2;
      q     = m >> 16;
      bound = longint'(lim) * longint'(n - 1);
      return (q > bound) || (q == bound && m[15:0] != 0);
    endfunction

    function void push_result(logic [1:0] st);
      cal_result_t r;
      r.status = st;
      r.count  = n_samples[8:0];
      foreach (r.mean[i]) r.mean[i] = rounded_mean(mean_acc[i]);
      expected_results.push_back(r);
    endfunction

    // Called for every accepted input beat.
    function void note_input(imu_beat_t b);
      longint norm, x, delta, d1, d2, g;
      if (b.restart) begin
        clear_session();
        push_result(imu_cal_pkg::ST_OK);
        return;
      end
      if (rejected || n_samples >= TARGET) begin
        push_result(imu_cal_pkg::ST_INV);
        return;
      end
      norm = 0;
      for (int i = 0; i < 3; i++) begin
        g = b.ch[3 + i];
        if (g < 0) g = -g;
        if (g > rate_lim) begin
          rejected = 1;
          push_result(imu_cal_pkg::ST_REJ);
          return;
        end
        norm += longint'(b.ch[i]) * longint'(b.ch[i]);
      end
      if (norm < longint'(norm_lo) || norm > longint'(norm_hi)) begin
        rejected = 1;
        push_result(imu_cal_pkg::ST_REJ);
        return;
      end
      n_samples++;
      for (int i = 0; i < 6; i++) begin
        x     = longint'(b.ch[i]) <<< FRAC;
        delta = x - mean_acc[i];
        // SystemVerilog division truncates toward zero, as the block does.
        mean_acc[i] += delta / longint'(n_samples);
        d1 = delta >>> (FRAC - 8);
        d2 = (x - mean_acc[i]) >>> (FRAC - 8);
        m2_acc[i] = sat_sum(m2_acc[i], d1 * d2);
      end
      if (n_samples < TARGET) begin
        push_result(imu_cal_pkg::ST_OK);
        return;
      end
      // Session complete: variance limits, then gyro bias.
      for (int i = 0; i < 3; i++) begin
        if (variance_over(m2_acc[i], acc_var_lim, n_samples) ||
            variance_over(m2_acc[3 + i], gyro_var_lim, n_samples)) begin
          rejected = 1;
          push_result(imu_cal_pkg::ST_REJ);
          return;
        end
      end
      for (int i = 3; i < 6; i++) begin
        g = mean_acc[i];
        if (g < 0) g = -g;
        if (g > (longint'(bias_lim) <<< FRAC)) begin
          rejected = 1;
          push_result(imu_cal_pkg::ST_REJ);
          return;
        end
      end
      push_result(imu_cal_pkg::ST_PASS);
    endfunction

    task report(string what, longint exp_v, longint got_v);
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [111:0] d);
      cal_result_t e;
      if (expected_results.size() == 0) begin
        report("unexpected result beat", 0, st);
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) report("status", e.status, st);
      if (d[8:0] !== e.count) report("samples_taken", e.count, d[8:0]);
      for (int i = 0; i < 6; i++)
        if (d[9 + 16 * i +: 16] !== e.mean[i]) report($sformatf("mean[%0d]", i), e.mean[i],
                                                      d[9 + 16 * i +: 16]);
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  logic         in_tuser;   // action
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // samples_taken, accel_mean_x/y/z, gyro_mean_x/y/z, zero pad
  logic [1:0]   out_tuser;  // status
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  calib_scoreboard sb = new();

  // Idle percentages for each side; changed per test phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  imu_static_calibration_welford u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The receiver stalls at random; the decision is made at the falling edge.
  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every result beat is checked at the rising edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // Drive one beat. in_tvalid stays high on return, so back-to-back beats
  // never drop it; only an idle gap or a drain lowers it.
  task send_beat(imu_beat_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = b.restart;
    for (int i = 0; i < 6; i++) in_tdata[16 * i +: 16] = b.ch[i];
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
  endtask

  // Lower valid and wait until every expected result beat has come back.
  task drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_regs(logic [14:0] rate, logic [31:0] lo, logic [31:0] hi,
                  logic [31:0] acc_var, logic [31:0] gyr_var, logic [14:0] bias);
    logic [31:0] vals[6];
    logic [2:0]  idx[6];
    vals = '{32'(rate), lo, hi, acc_var, gyr_var, 32'(bias)};
    idx  = '{imu_cal_pkg::REG_GYRO_RATE, imu_cal_pkg::REG_NORM_LO, imu_cal_pkg::REG_NORM_HI,
             imu_cal_pkg::REG_ACC_VAR, imu_cal_pkg::REG_GYRO_VAR, imu_cal_pkg::REG_GYRO_BIAS};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_addr  = idx[i];
      cfg_wdata = vals[i];
      sb.set_reg(idx[i], vals[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function imu_beat_t make_beat(bit rs, int ax, int ay, int az, int gx, int gy, int gz);
    imu_beat_t b;
    b.restart = rs;
    b.ch = '{shortint'(ax), shortint'(ay), shortint'(az),
             shortint'(gx), shortint'(gy), shortint'(gz)};
    return b;
  endfunction

  // A sample from a unit at rest, z axis up, with small noise and gyro bias.
  function imu_beat_t still_sample(int bias);
    return make_beat(0, int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                     16384 + int'($urandom_range(0, 200)) - 100,
                     bias + int'($urandom_range(0, 120)) - 60, int'($urandom_range(0, 120)) - 60,
                     int'($urandom_range(0, 120)) - 60);
  endfunction

  task restart_session();
    send_beat(make_beat(1, 0, 0, 0, 0, 0, 0));
  endtask

  // A full session of well-formed samples, followed by a few adds that the
  // full session must ignore.
  task full_session(int bias);
    restart_session();
    for (int k = 0; k < TARGET; k++) begin
      // Once, in the middle, hold back until every result is back.
      if (k == TARGET / 2) drain();
      send_beat(still_sample(bias));
    end
    repeat (3) send_beat(still_sample(bias));
  endtask

  initial begin
    imu_beat_t b;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = imu_cal_pkg::REG_GYRO_RATE;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at the reset register values, no idling.
    restart_session();
    send_beat(make_beat(0, 0, 0, 16384, 0, 0, 0));
    send_beat(make_beat(0, 100, -100, 16000, 1280, -1280, 0));      // gyro at the limit
    send_beat(make_beat(0, 0, 0, -16384, -1280, 1280, -1280));
    send_beat(make_beat(0, 0, 0, 16384, 0, 0, 1281));               // gyro just over
    send_beat(make_beat(0, 0, 0, 16384, 0, 0, 0));                  // ignored, rejected
    restart_session();
    send_beat(make_beat(0, 0, 0, 14000, 0, 0, 0));                  // norm too small
    restart_session();
    send_beat(make_beat(0, 0, 0, 19000, 0, 0, 0));                  // norm too large
    restart_session();
    send_beat(make_beat(0, -32768, 32767, -32768, 0, 0, 0));
    restart_session();
    send_beat(make_beat(0, 0, 16384, 0, -32768, 0, 0));
    restart_session();
    send_beat(make_beat(0, 0, 0, 16384, 0, 32767, 0));
    restart_session();
    send_beat(make_beat(0, 11585, 11585, 0, -1, 1, 0));
    send_beat(make_beat(0, 0, -16384, 0, 5, -7, 3));
    drain();

    // Wide-open registers; full-range random content reaches every bit.
    send_idle_pct = 57;
    write_regs(15'h7FFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
    for (int k = 0; k < 60; k++) begin
      b = make_beat(($urandom_range(0, 7) == 0), int'($urandom()), int'($urandom()),
                    int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
      send_beat(b);
    end
    drain();

    // Reset values again: a quiet session that completes and passes.
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    write_regs(imu_cal_pkg::RST_GYRO_RATE, imu_cal_pkg::RST_NORM_LO, imu_cal_pkg::RST_NORM_HI,
               imu_cal_pkg::RST_ACC_VAR, imu_cal_pkg::RST_GYRO_VAR,
               imu_cal_pkg::RST_GYRO_BIAS);
    full_session(int'($urandom_range(0, 200)) - 100);
    drain();

    // Mixed short sessions: mostly good samples, some bad ones and restarts.
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    write_regs(15'd200, imu_cal_pkg::RST_NORM_LO, imu_cal_pkg::RST_NORM_HI,
               imu_cal_pkg::RST_ACC_VAR, imu_cal_pkg::RST_GYRO_VAR, 15'd100);
    for (int k = 0; k < 110; k++) begin
      case ($urandom_range(0, 9))
        0:       restart_session();
        1:       send_beat(make_beat(0, int'($urandom()), int'($urandom()), int'($urandom()),
                                     int'($urandom()), int'($urandom()), int'($urandom())));
        default: send_beat(still_sample(0));
      endcase
    end
    drain();

    if (sb.errors == 0) begin
      $display("imu_static_calibration_welford test passed");
    end else begin
      $display("imu_static_calibration_welford test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("imu_static_calibration_welford test failed");
    $finish;
  end

endmodule
